// ===== sv/iir_lowpass_decimate_by_two_assert.svh =====
// ----------------------------------------------------------------------------
// iir_lowpass_decimate_by_two_assert.svh
// Assertion macros shared by the decimating low-pass filter.
// ----------------------------------------------------------------------------
`ifndef IIR_LOWPASS_DECIMATE_BY_TWO_ASSERT_SVH
`define IIR_LOWPASS_DECIMATE_BY_TWO_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IIRLD2_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define IIRLD2_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== sv/iirld2_pkg.sv =====
// ----------------------------------------------------------------------------
// iirld2_pkg
// Shared constants, coefficient tables and types of the decimating filter.
// ----------------------------------------------------------------------------
package iirld2_pkg;

   // default widths
   localparam int SAMPLE_BITS_DEF     = 24;
   localparam int GUARD_FRAC_BITS_DEF = 16;
   localparam int COEF_FRAC_BITS_DEF  = 30;

   // filter order (feedback taps, cells in the chain)
   localparam int TAPS = 8;

   // coefficients as stored, Q6.30; feed-forward is symmetric (a8..a5 = a0..a3)
   localparam int TABLE_FRAC = 30;
   localparam longint FF_Q30 [0:4] = '{
      64'sd372685, 64'sd2981480, 64'sd10435180, 64'sd20870361, 64'sd26087951
   };
   localparam longint FB_Q30 [0:TAPS-1] = '{
      -64'sd4150629895, 64'sd8871755212, -64'sd12556236526, 64'sd12643966803,
      -64'sd9174273629, 64'sd4677113403, -64'sd1540078000, 64'sd255701413
   };

   // per-cell control
   typedef struct packed {
      logic advance;  // an item moves through the chain this cycle
      logic clear;    // the item starts a block: neighbor sums count as zero
   } cell_ctrl_type;

   // rescale a Q6.30 value to cf fraction bits, rounding half up when narrowing
   function automatic longint scale_coef(longint q, int cf);
      longint half;
      half = 64'sd0;
      if (cf >= TABLE_FRAC) begin
         return q <<< (cf - TABLE_FRAC);
      end
      half = 64'sd1 <<< (TABLE_FRAC - cf - 1);
      return (q + half) >>> (TABLE_FRAC - cf);
   endfunction

   // feed-forward coefficient a_k, k = 0..TAPS
   function automatic longint ff_coef(int k, int cf);
      int fi;
      fi = (k <= 4) ? k : TAPS - k;
      return scale_coef(FF_Q30[fi], cf);
   endfunction

   // negated feedback coefficient -b_k, k = 1..TAPS (negated after rounding)
   function automatic longint fb_coef_neg(int k, int cf);
      return -scale_coef(FB_Q30[k-1], cf);
   endfunction

endpackage

// ===== sv/iirld2_round_sat.sv =====
// ----------------------------------------------------------------------------
// iirld2_round_sat
// Signed right shift with round half up, saturated to the output width.
// ----------------------------------------------------------------------------
module iirld2_round_sat #(
   parameter int IN_W  = 80,
   parameter int SHIFT = 30,
   parameter int OUT_W = 40
) (
   input  logic signed [IN_W-1:0]  din,
   output logic signed [OUT_W-1:0] dout
);

   localparam int SUM_W = IN_W + 1;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);

   logic        [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   shifted;
   logic        [SUM_W-OUT_W:0] hi;

   // add half an LSB, then arithmetic shift
   assign sum     = {din[IN_W-1], din} + HALF;
   assign shifted = $signed(sum) >>> SHIFT;

   // in range when every bit above the output sign agrees with it
   assign hi = shifted[SUM_W-1:OUT_W-1];

   always_comb begin
      if ((~|hi) || (&hi)) begin
         dout = shifted[OUT_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         dout = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         dout = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

endmodule

// ===== sv/iirld2_cell.sv =====
// ----------------------------------------------------------------------------
// iirld2_cell
// One section of the transposed filter: holds a partial sum of the exact
// accumulator and passes it toward the head of the chain.
// ----------------------------------------------------------------------------
module iirld2_cell #(
   parameter int     HIST_W  = 40,
   parameter int     COEF_W  = 35,
   parameter int     ACC_W   = 76,
   parameter longint A_COEF  = 64'sd0,
   parameter longint NB_COEF = 64'sd0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  iirld2_pkg::cell_ctrl_type    ctrl,
   input  logic signed [HIST_W-1:0]     x_g,     // input sample with guard bits
   input  logic signed [HIST_W-1:0]     y_fb,    // new filtered value
   input  logic signed [ACC_W-1:0]      s_down,  // sum of the next cell
   output logic signed [ACC_W-1:0]      s_up     // this cell's sum
);

   localparam int PROD_W = HIST_W + COEF_W;
   localparam logic signed [COEF_W-1:0] A_C  = COEF_W'(A_COEF);
   localparam logic signed [COEF_W-1:0] NB_C = COEF_W'(NB_COEF);

   logic signed [PROD_W-1:0] ff_p;
   logic signed [PROD_W-1:0] fb_p;
   logic signed [ACC_W-1:0]  s_ff;
   logic signed [ACC_W-1:0]  s_in;

   // feed-forward and feedback terms of this tap
   assign ff_p = A_C * x_g;
   assign fb_p = NB_C * y_fb;

   // add the neighbor's sum unless the block restarts
   always_comb begin
      s_in = ACC_W'(ff_p) + ACC_W'(fb_p);
      if (!ctrl.clear) begin
         s_in = s_in + s_down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
      end else if (ctrl.advance) begin
         s_ff <= s_in;
      end
   end

   assign s_up = s_ff;

endmodule

// ===== sv/iir_lowpass_decimate_by_two.sv =====
// ----------------------------------------------------------------------------
// iir_lowpass_decimate_by_two
// 8th-order Chebyshev-I low-pass IIR with decimation by two.
// ----------------------------------------------------------------------------
//  channel  | ports  | tdata (low bit up)            | tuser          | tlast
//  ---------+--------+-------------------------------+----------------+--------------
//  input    | req_*  | sample, zero pad to bytes     | first_of_block | last_of_block
//  result   | rsp_*  | decimated_sample, zero pad    | -              | last_out
//
//  One sample per cycle unless the input stage is held. The recursion closes
//  through the head round/saturate and the feedback multiply-add of the first cell.
//  A result enters the output register as its releasing odd sample leaves
//  the input stage; one result for every second sample of a block.
//  Reset (synchronous) zeroes the cell sums, the phase and the valid flags.
//  A stalled result only holds the input stage when the waiting sample
//  would produce another result; otherwise samples keep flowing.
// ----------------------------------------------------------------------------
module iir_lowpass_decimate_by_two #(
   parameter  int SAMPLE_BITS     = iirld2_pkg::SAMPLE_BITS_DEF,
   parameter  int GUARD_FRAC_BITS = iirld2_pkg::GUARD_FRAC_BITS_DEF,
   parameter  int COEF_FRAC_BITS  = iirld2_pkg::COEF_FRAC_BITS_DEF,
   localparam int TDATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // sample, zero pad
   input  logic               req_tuser,   // first_of_block
   input  logic               req_tlast,   // last_of_block
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // decimated_sample, zero pad
   output logic               rsp_tlast    // last_out
);

   localparam int TAPS   = iirld2_pkg::TAPS;
   localparam int HIST_W = SAMPLE_BITS + GUARD_FRAC_BITS;
   localparam int COEF_W = COEF_FRAC_BITS + 5;
   localparam int PROD_W = HIST_W + COEF_W;
   localparam int ACC_W  = HIST_W + COEF_FRAC_BITS + 6;
   localparam logic signed [COEF_W-1:0] A0_C =
      COEF_W'(iirld2_pkg::ff_coef(0, COEF_FRAC_BITS));

   // input stage
   logic                          req_acc;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic signed [HIST_W-1:0]      req_xg;
   logic signed [PROD_W-1:0]      p0_in;
   logic                          a_valid_ff;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic                          a_first_ff;
   logic                          a_last_ff;
   logic signed [PROD_W-1:0]      a_p0_ff;

   // chain and head
   logic signed [HIST_W-1:0]      b_xg;
   logic signed [ACC_W-1:0]       s_chain [1:TAPS+1];
   logic signed [ACC_W-1:0]       head_acc;
   logic signed [HIST_W-1:0]      y_hist;
   logic signed [SAMPLE_BITS-1:0] o_sample;
   iirld2_pkg::cell_ctrl_type     ctrl;

   // decimation and output
   logic                          phase_eff;
   logic                          fire_b;
   logic                          out_free;
   logic                          odd_phase_ff;
   logic                          odd_phase_in;
   logic [SAMPLE_BITS-1:0]        held_ff;
   logic                          out_valid_ff;
   logic [SAMPLE_BITS-1:0]        out_data_ff;
   logic                          out_last_ff;

   // accept; the a0 product is formed ahead of the recursion
   assign req_acc    = req_tvalid && req_tready;
   assign req_sample = $signed(req_tdata[SAMPLE_BITS-1:0]);
   assign req_xg     = $signed({req_sample, {GUARD_FRAC_BITS{1'b0}}});
   assign p0_in      = A0_C * req_xg;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_acc) begin
         a_valid_ff <= 1'b1;
      end else if (fire_b) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_sample_ff <= req_sample;
         a_first_ff  <= req_tuser;
         a_last_ff   <= req_tlast;
         a_p0_ff     <= p0_in;
      end
   end

   // the item in the input stage moves on unless it needs a busy output
   assign phase_eff  = odd_phase_ff && !a_first_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire_b     = a_valid_ff && (!phase_eff || out_free);
   assign req_tready = !a_valid_ff || fire_b;

   // head of the chain: y = round(a0*x + s1)
   assign b_xg     = $signed({a_sample_ff, {GUARD_FRAC_BITS{1'b0}}});
   assign head_acc = ACC_W'(a_p0_ff) + (a_first_ff ? ACC_W'(0) : s_chain[1]);

   iirld2_round_sat #(
      .IN_W  (ACC_W),
      .SHIFT (COEF_FRAC_BITS),
      .OUT_W (HIST_W)
   ) u_hist_round (
      .din  (head_acc),
      .dout (y_hist)
   );

   iirld2_round_sat #(
      .IN_W  (HIST_W),
      .SHIFT (GUARD_FRAC_BITS),
      .OUT_W (SAMPLE_BITS)
   ) u_out_round (
      .din  (y_hist),
      .dout (o_sample)
   );

   // chain of cells, the last one sees a zero neighbor
   assign ctrl.advance     = fire_b;
   assign ctrl.clear       = a_first_ff;
   assign s_chain[TAPS+1]  = '0;

   for (genvar j = 1; j <= TAPS; j++) begin : g_cell
      iirld2_cell #(
         .HIST_W  (HIST_W),
         .COEF_W  (COEF_W),
         .ACC_W   (ACC_W),
         .A_COEF  (iirld2_pkg::ff_coef(j, COEF_FRAC_BITS)),
         .NB_COEF (iirld2_pkg::fb_coef_neg(j, COEF_FRAC_BITS))
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .x_g    (b_xg),
         .y_fb   (y_hist),
         .s_down (s_chain[j+1]),
         .s_up   (s_chain[j])
      );
   end

   // phase: even samples are held, odd ones release the held value
   always_comb begin
      odd_phase_in = odd_phase_ff;
      if (fire_b) begin
         odd_phase_in = a_last_ff ? 1'b0 : !phase_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_phase_ff <= 1'b0;
      end else begin
         odd_phase_ff <= odd_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_b && !phase_eff) begin
         held_ff <= o_sample;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire_b && phase_eff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_b && phase_eff) begin
         out_data_ff <= held_ff;
         out_last_ff <= a_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_W'(out_data_ff);
   assign rsp_tlast  = out_last_ff;

   // checks
`include "iir_lowpass_decimate_by_two_assert.svh"

   `IIRLD2_ASSERT_NEXT(a_emit_loads_out, fire_b && phase_eff, out_valid_ff,
      "released sample did not reach the output register")
   `IIRLD2_ASSERT_NOW(a_no_overwrite, out_valid_ff && !rsp_tready,
      !(fire_b && phase_eff), "waiting result overwritten")
   `IIRLD2_ASSERT_NEXT(a_last_resets_phase, fire_b && a_last_ff, !odd_phase_ff,
      "phase not even after the last sample of a block")
   `IIRLD2_ASSERT_NEXT(a_first_is_even, fire_b && a_first_ff && !a_last_ff, odd_phase_ff,
      "first sample of a block not treated as even")

endmodule
